>>> rtl/core/bsst_pkg.sv
// Shared types and constants for the sorted-table binary search block.
// No dependencies; used by bsst_ram and binary_search_sorted_table.
package bsst_pkg;

    localparam int WORD_W  = 32;
    localparam int IDX_W   = 10;
    localparam int LEN_W   = 11;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    typedef enum logic
    {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } req_kind_t;

endpackage

>>> rtl/core/binary_search_sorted_table.sv
// Sorted table of signed words with an iterative binary search sequencer.
// Depends on bsst_pkg and bsst_ram.
//
// Usage:
//   The s_ channel carries requests. s_tuser is the request kind (write or
//   search); a write stores entry_value at entry_index and gives no result,
//   a search looks for search_key among entries 0 .. table_length-1, capped at DEPTH.
//   The m_ channel returns one result per search: m_tuser is the found flag,
//   m_tdata the matching position (zero when not found).
//   The cfg_ channel writes table_length; write it only while idle.
// Timing:
//   A write is stored at acceptance and leaves the sequencer idle. A search
//   runs P probes, P being at most 11 for 1024 entries, and a hit ends it;
//   each probe is a read state and a compare state. s_tready stays low until
//   the result is loaded into the output register and rises along with it.
// Reset:
//   table_length clears to zero; table contents are undefined until written.
// Stall:
//   A result waits in the output register while m_tready is low; a search
//   that finishes meanwhile holds its result until the register frees up.
module binary_search_sorted_table #(
    parameter int DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata fields, low bit up: entry_index[9:0], entry_value[31:0],
    // search_key[31:0], zero padding.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bsst_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser fields: req_type.
    input  logic                           s_tuser,
    // m_tdata fields, low bit up: position[9:0], zero padding.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bsst_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser fields: found.
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsst_pkg::LEN_W-1:0]     cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = AW + 1;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [bsst_pkg::LEN_W-1:0]      len_reg;
    logic [LW-1:0]                   lo_reg;
    logic [LW-1:0]                   hi_reg;     // exclusive upper bound
    logic [AW-1:0]                   mid_reg;
    logic signed [bsst_pkg::WORD_W-1:0] key_reg;
    logic                            hit_reg;
    logic [bsst_pkg::IDX_W-1:0]      pos_reg;
    logic                            m_tvalid_reg;
    logic                            m_found_reg;
    logic [bsst_pkg::IDX_W-1:0]      m_pos_reg;

    logic [bsst_pkg::IDX_W-1:0]      in_index;
    logic [bsst_pkg::WORD_W-1:0]     in_value;
    logic [bsst_pkg::WORD_W-1:0]     in_key;
    logic                            s_accept;
    logic                            wr_en;
    logic [LW-1:0]                   hi_init;
    logic [LW:0]                     mid_sum;
    logic [AW-1:0]                   mid;
    logic                            rd_en;
    logic [bsst_pkg::WORD_W-1:0]     rd_data;
    logic signed [bsst_pkg::WORD_W-1:0] probe_word;
    logic                            out_free;

    assign in_index = s_tdata[bsst_pkg::IDX_W-1:0];
    assign in_value = s_tdata[bsst_pkg::IDX_W +: bsst_pkg::WORD_W];
    assign in_key   = s_tdata[bsst_pkg::IDX_W + bsst_pkg::WORD_W +: bsst_pkg::WORD_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    // Writes beyond the table depth are dropped.
    assign wr_en = s_accept && (s_tuser == bsst_pkg::REQ_WRITE)
                   && (32'(in_index) < DEPTH);

    // The search covers at most DEPTH entries.
    assign hi_init = (32'(len_reg) > DEPTH) ? LW'(DEPTH) : LW'(len_reg);

    // floor((low + high) / 2) with high = hi_reg - 1; valid while lo_reg < hi_reg.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (LW+1)'(1);
    assign mid     = mid_sum[AW:1];

    assign rd_en      = (state_reg == ST_READ) && (lo_reg < hi_reg);
    assign probe_word = rd_data;
    assign out_free   = !m_tvalid_reg || m_tready;

    bsst_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(in_index)),
        .wdata (in_value),
        .re    (rd_en),
        .raddr (mid),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            key_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            mid_reg      <= '0;
            hit_reg      <= 1'b0;
            pos_reg      <= '0;
            m_found_reg  <= 1'b0;
            m_pos_reg    <= '0;
        end
        else
        begin
            // In ST_DONE the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept && (s_tuser == bsst_pkg::REQ_SEARCH))
                    begin
                        key_reg   <= in_key;
                        lo_reg    <= '0;
                        hi_reg    <= hi_init;
                        hit_reg   <= 1'b0;
                        pos_reg   <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid;
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_CMP:
                begin
                    if (probe_word == key_reg)
                    begin
                        hit_reg   <= 1'b1;
                        pos_reg   <= bsst_pkg::IDX_W'(mid_reg);
                        state_reg <= ST_DONE;
                    end
                    else if (key_reg < probe_word)
                    begin
                        hi_reg    <= LW'(mid_reg);
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        lo_reg    <= LW'(mid_reg) + LW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_found_reg  <= hit_reg;
                        m_pos_reg    <= pos_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(bsst_pkg::M_TDATA_W - bsst_pkg::IDX_W){1'b0}}, m_pos_reg};

`ifndef ASSERT_OFF
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (lo_reg <= hi_reg && 32'(hi_reg) <= DEPTH))
        else $error("search bounds out of order or beyond table depth");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (LW'(mid_reg) >= lo_reg && LW'(mid_reg) < hi_reg))
        else $error("probe index outside the live search window");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !hit_reg) |-> (pos_reg == '0))
        else $error("missed search carries a nonzero position");

    a_result_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_pos_reg)
                                          && $stable(m_found_reg)))
        else $error("pending result overwritten while stalled");
`endif

endmodule

>>> rtl/core/bsst_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
// Depends on bsst_pkg for the word width.
module bsst_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bsst_pkg::WORD_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [bsst_pkg::WORD_W-1:0] rdata
);

    logic [bsst_pkg::WORD_W-1:0] mem [DEPTH];
    logic [bsst_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
